// File: src/kbsd_pkg.sv
package kbsd_pkg;

    localparam int unsigned SIZE_W = 6;
    localparam int unsigned MER_W  = 64;
    localparam int unsigned POS_W  = 40;
    localparam int unsigned ID_W   = 32;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned SKIP_W = 8;
    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    localparam logic [SIZE_W-1:0] MAX_MER      = 6'd32;
    localparam logic [SIZE_W-1:0] RST_SIZE     = 6'd20;
    localparam logic [SKIP_W-1:0] RST_SKIP     = 8'd0;
    localparam logic [1:0]        CMP_BITS     = 2'h3;

    localparam logic [1:0] REG_FILE_SIZE   = 2'd0;
    localparam logic [1:0] REG_WANTED_SIZE = 2'd1;
    localparam logic [1:0] REG_SKIP_COUNT  = 2'd2;

    localparam logic ACT_DESC = 1'b0;
    localparam logic ACT_BASE = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_DROP = 4'b0010,
        PH_FILL = 4'b0100,
        PH_RUN  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [SIZE_W-1:0] mer_size_file;
        logic [SIZE_W-1:0] mer_size_wanted;
        logic [SKIP_W-1:0] skip_count;
    } t_cfg;

    typedef struct packed {
        logic              action;
        logic [1:0]        base_code;
        logic [CNT_W-1:0]  block_mers;
        logic [ID_W-1:0]   block_seq_id;
        logic [POS_W-1:0]  block_seq_pos;
        logic [POS_W-1:0]  block_stream_pos;
    } t_in_word;

    typedef struct packed {
        logic [MER_W-1:0] fwd_mer;
        logic [MER_W-1:0] rev_mer;
        logic [POS_W-1:0] mer_seq_pos;
        logic [POS_W-1:0] mer_stream_pos;
        logic [ID_W-1:0]  mer_seq_id;
    } t_res;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = 6'd1;
        end else if (v > MAX_MER) begin
            r = MAX_MER;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [MER_W-1:0] mer_mask(input logic [SIZE_W-1:0] w);
        logic [MER_W-1:0] m;
        for (int i = 0; i < MER_W/2; i++) begin
            m[2*i +: 2] = (SIZE_W'(i) < w) ? 2'b11 : 2'b00;
        end
        return m;
    endfunction

endpackage

// File: src/kbsd_cfg.sv
module kbsd_cfg
    import kbsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mer_size_file   <= RST_SIZE;
            r_cfg.mer_size_wanted <= RST_SIZE;
            r_cfg.skip_count      <= RST_SKIP;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FILE_SIZE:   r_cfg.mer_size_file   <= pwdata[SIZE_W-1:0];
                REG_WANTED_SIZE: r_cfg.mer_size_wanted <= pwdata[SIZE_W-1:0];
                REG_SKIP_COUNT:  r_cfg.skip_count      <= pwdata[SKIP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FILE_SIZE:   prdata = {{(APB_DW-SIZE_W){1'b0}}, r_cfg.mer_size_file};
            REG_WANTED_SIZE: prdata = {{(APB_DW-SIZE_W){1'b0}}, r_cfg.mer_size_wanted};
            REG_SKIP_COUNT:  prdata = {{(APB_DW-SKIP_W){1'b0}}, r_cfg.skip_count};
            default:         prdata = '0;
        endcase
    end

endmodule

// File: src/kbsd_core.sv
module kbsd_core
    import kbsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_word i_word,
    input  t_cfg     i_cfg,
    output logic     o_res_valid,
    output t_res     o_res
);

    t_phase            r_phase, n_phase;
    logic [MER_W-1:0]  r_fwd, n_fwd;
    logic [MER_W-1:0]  r_rev, n_rev;
    logic [SIZE_W-1:0] r_fill_left, n_fill_left;
    logic [SIZE_W-1:0] r_drop_left, n_drop_left;
    logic [CNT_W-1:0]  r_mers_left, n_mers_left;
    logic [POS_W-1:0]  r_seq_pos, n_seq_pos;
    logic [POS_W-1:0]  r_stream_pos, n_stream_pos;
    logic [ID_W-1:0]   r_seq_id, n_seq_id;
    logic [SKIP_W-1:0] r_skip_cnt, n_skip_cnt;
    logic [SIZE_W-1:0] r_blk_w, n_blk_w;

    logic [SIZE_W-1:0] f_size;
    logic [SIZE_W-1:0] w_clamp;
    logic [SIZE_W-1:0] w_size;
    logic [SIZE_W-1:0] diff;
    logic [MER_W-1:0]  mask;
    logic [6:0]        ins_sh;
    logic [MER_W-1:0]  ins;
    logic [MER_W-1:0]  sh_fwd;
    logic [MER_W-1:0]  sh_rev;
    logic [SIZE_W-1:0] fill_dec;
    logic [CNT_W-1:0]  mers_dec;
    logic              finish;

    assign f_size  = clamp_size(i_cfg.mer_size_file);
    assign w_clamp = clamp_size(i_cfg.mer_size_wanted);
    assign w_size  = (w_clamp < f_size) ? f_size : w_clamp;
    assign diff    = w_size - f_size;

    // shifting always uses the size held for the open block
    assign mask   = mer_mask(r_blk_w);
    assign ins_sh = {r_blk_w, 1'b0} - 7'd2;
    assign ins    = {{(MER_W-2){1'b0}}, i_word.base_code ^ CMP_BITS} << ins_sh;
    assign sh_fwd = {r_fwd[MER_W-3:0], i_word.base_code} & mask;
    assign sh_rev = ((r_rev >> 2) | ins) & mask;

    assign fill_dec = r_fill_left - 6'd1;
    assign mers_dec = r_mers_left - 32'd1;

    always_comb begin
        n_phase      = r_phase;
        n_fwd        = r_fwd;
        n_rev        = r_rev;
        n_fill_left  = r_fill_left;
        n_drop_left  = r_drop_left;
        n_mers_left  = r_mers_left;
        n_seq_pos    = r_seq_pos;
        n_stream_pos = r_stream_pos;
        n_seq_id     = r_seq_id;
        n_blk_w      = r_blk_w;
        finish       = 1'b0;

        if (i_word.action == ACT_DESC) begin
            n_blk_w = w_size;
            if (i_word.block_mers <= {{(CNT_W-SIZE_W){1'b0}}, diff}) begin
                // block too short: drop its bases (block_mers fits 6 bits here)
                n_drop_left = f_size + i_word.block_mers[SIZE_W-1:0] - 6'd1;
                n_phase     = (n_drop_left == '0) ? PH_IDLE : PH_DROP;
            end else begin
                n_mers_left  = i_word.block_mers - {{(CNT_W-SIZE_W){1'b0}}, diff} - 32'd1;
                n_fill_left  = w_size;
                n_seq_id     = i_word.block_seq_id;
                n_seq_pos    = i_word.block_seq_pos;
                n_stream_pos = i_word.block_stream_pos;
                n_fwd        = '0;
                n_rev        = '0;
                n_phase      = PH_FILL;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_DROP: begin
                    n_drop_left = r_drop_left - 6'd1;
                    if (n_drop_left == '0) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_FILL: begin
                    n_fwd       = sh_fwd;
                    n_rev       = sh_rev;
                    n_fill_left = fill_dec;
                    if (fill_dec == '0) begin
                        n_phase = (r_mers_left != '0) ? PH_RUN : PH_IDLE;
                        finish  = 1'b1;
                    end
                end
                PH_RUN: begin
                    n_fwd        = sh_fwd;
                    n_rev        = sh_rev;
                    n_mers_left  = mers_dec;
                    n_seq_pos    = r_seq_pos + 40'd1;
                    n_stream_pos = r_stream_pos + 40'd1;
                    if (mers_dec == '0) begin
                        n_phase = PH_IDLE;
                    end
                    finish = 1'b1;
                end
                default: n_phase = PH_IDLE;
            endcase
        end

        n_skip_cnt  = r_skip_cnt;
        o_res_valid = 1'b0;
        if (finish) begin
            if (r_skip_cnt >= i_cfg.skip_count) begin
                n_skip_cnt  = '0;
                o_res_valid = 1'b1;
            end else begin
                n_skip_cnt = r_skip_cnt + 8'd1;
            end
        end
    end

    assign o_res.fwd_mer        = n_fwd;
    assign o_res.rev_mer        = n_rev;
    assign o_res.mer_seq_pos    = n_seq_pos;
    assign o_res.mer_stream_pos = n_stream_pos;
    assign o_res.mer_seq_id     = n_seq_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_fill_left <= '0;
            r_drop_left <= '0;
            r_mers_left <= '0;
            r_skip_cnt  <= '0;
            r_blk_w     <= RST_SIZE;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_fill_left <= n_fill_left;
            r_drop_left <= n_drop_left;
            r_mers_left <= n_mers_left;
            r_skip_cnt  <= n_skip_cnt;
            r_blk_w     <= n_blk_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_fwd        <= n_fwd;
            r_rev        <= n_rev;
            r_seq_pos    <= n_seq_pos;
            r_stream_pos <= n_stream_pos;
            r_seq_id     <= n_seq_id;
        end
    end

endmodule

// File: src/kmer_block_stream_decoder_top.sv
// Throughput: one input word per cycle while the output is not stalled.
// Path of a word: input register, one step of decode, output register.
// A stalled output holds one word in the input register, then input ready drops.
// Reset (synchronous, active low): no open block, skip counter zero, both registers empty,
// mer sizes 20 and skip count 0.
module kmer_block_stream_decoder_top
    import kbsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_action,
    input  logic [1:0]        i_base_code,
    input  logic [CNT_W-1:0]  i_block_mers,
    input  logic [ID_W-1:0]   i_block_seq_id,
    input  logic [POS_W-1:0]  i_block_seq_pos,
    input  logic [POS_W-1:0]  i_block_stream_pos,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [MER_W-1:0]  o_fwd_mer,
    output logic [MER_W-1:0]  o_rev_mer,
    output logic [POS_W-1:0]  o_mer_seq_pos,
    output logic [POS_W-1:0]  o_mer_stream_pos,
    output logic [ID_W-1:0]   o_mer_seq_id
);

    t_cfg     cfg;
    logic     r_in_valid;
    t_in_word r_in;
    logic     r_out_valid;
    t_res     r_out;
    logic     advance;
    logic     step;
    logic     res_valid;
    t_res     res;

    kbsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.action           <= i_action;
            r_in.base_code        <= i_base_code;
            r_in.block_mers       <= i_block_mers;
            r_in.block_seq_id     <= i_block_seq_id;
            r_in.block_seq_pos    <= i_block_seq_pos;
            r_in.block_stream_pos <= i_block_stream_pos;
        end
    end

    kbsd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_word      (r_in),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_fwd_mer        = r_out.fwd_mer;
    assign o_rev_mer        = r_out.rev_mer;
    assign o_mer_seq_pos    = r_out.mer_seq_pos;
    assign o_mer_stream_pos = r_out.mer_stream_pos;
    assign o_mer_seq_id     = r_out.mer_seq_id;

endmodule
